@@ src/bmpd_pkg.sv @@
package bmpd_pkg;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_JUDGE,
		PH_BODY,
		PH_EMIT,
		PH_DRAIN
	} phase_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_SHORT      = 3'd1,
		ERR_SIGNATURE  = 3'd2,
		ERR_COMPRESSED = 3'd3,
		ERR_DEPTH      = 3'd4,
		ERR_OVERRUN    = 3'd5,
		ERR_TOO_LARGE  = 3'd6
	} err_t;

	localparam logic [31:0] HEADER_BYTES = 32'd54;
	localparam logic [7:0]  SIG_B = 8'h42;
	localparam logic [7:0]  SIG_M = 8'h4d;

	typedef struct packed {
		logic start;      // first byte of a file
		logic take_byte;  // header / body byte transfer
		logic judge_step; // one step of the overrun check
		logic emit_step;  // one pixel slot (or the palette wait) of the current byte
	} cmd_t;

	typedef struct packed {
		logic       file_end;    // this byte ends the file
		logic       short_file;
		logic       hdr_done;    // byte 53 taken
		logic       judge_done;
		err_t       judge_err;
		logic       byte_emits;  // body byte needs pixel slots
		logic       emit_done;   // last slot of the byte
		logic       slot_valid;  // current slot is a visible pixel
	} sts_t;

endpackage

@@ src/bmpd_ram.sv @@
module bmpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

@@ src/bmpd_ctrl.sv @@
module bmpd_ctrl import bmpd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic out_busy,
	input  sts_t sts,
	output cmd_t cmd,
	output logic in_ready,
	output logic err_push,
	output err_t err_code,
	output logic pix_push
);
	phase_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= PH_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		err_push = 1'b0;
		err_code = ERR_NONE;
		pix_push = 1'b0;
		case (state_q)
			PH_IDLE, PH_HEADER, PH_BODY, PH_DRAIN: begin
				in_ready = !out_busy;
				if (in_valid && !out_busy) begin
					cmd.take_byte = 1'b1;
					cmd.start = (state_q == PH_IDLE);
					if (state_q == PH_IDLE && sts.short_file) begin
						err_push = 1'b1;
						err_code = ERR_SHORT;
						state_d = sts.file_end ? PH_IDLE : PH_DRAIN;
					end else if (state_q == PH_IDLE || state_q == PH_HEADER) begin
						if (sts.hdr_done)
							state_d = PH_JUDGE;
						else if (sts.file_end)
							state_d = PH_IDLE;
						else
							state_d = PH_HEADER;
					end else if (state_q == PH_BODY && sts.byte_emits) begin
						state_d = PH_EMIT;
					end else if (sts.file_end) begin
						state_d = PH_IDLE;
					end
				end
			end
			PH_JUDGE: begin
				cmd.judge_step = 1'b1;
				if (sts.judge_done) begin
					if (sts.judge_err != ERR_NONE) begin
						err_push = !out_busy;
						err_code = sts.judge_err;
						if (!out_busy)
							state_d = sts.file_end ? PH_IDLE : PH_DRAIN;
						cmd.judge_step = 1'b0;
					end else begin
						state_d = sts.file_end ? PH_IDLE : PH_BODY;
					end
				end
			end
			PH_EMIT: begin
				if (!out_busy) begin
					cmd.emit_step = 1'b1;
					pix_push = sts.slot_valid;
					if (sts.emit_done)
						state_d = sts.file_end ? PH_IDLE : PH_BODY;
				end
			end
			default: state_d = PH_IDLE;
		endcase
	end
endmodule

@@ src/bmpd_dp.sv @@
module bmpd_dp import bmpd_pkg::*; #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] file_length,
	input  logic [7:0]  data_byte,
	input  cmd_t        cmd,
	output sts_t        sts,
	output logic [7:0]  blue,
	output logic [7:0]  green,
	output logic [7:0]  red,
	output logic [11:0] column,
	output logic [11:0] row,
	output logic        last
);
	logic [31:0] pos_q, hdr_q, off_q, rw_q, rh_q, comp_q, line_q;
	logic [15:0] depth_q;
	logic        sigbad_q, fend_q;
	logic [12:0] w_q, h_q;
	logic [4:0]  bpp_q;
	logic [14:0] rbc_q, prb_q;
	logic [12:0] rc_q;
	logic [15:0] part_q;
	logic [7:0]  byte_q;
	logic [14:0] cur_rbc_q;
	logic [12:0] cur_rc_q;
	logic [2:0]  slot_q;
	logic [12:0] x3_q;   // pixel column for 24 bpp
	logic [1:0]  m3_q;
	// rbc_q split as pixel index and byte within the pixel for 24 bpp
	logic [1:0]  m3c_q;
	logic [12:0] d3c_q;
	logic        rd_wait_q;
	logic [10:0] pal_cnt_q;  // palette bytes taken in this file
	logic        in_body_q;
	// overrun check: acc = off + line*h by shift-add, one bit a step
	logic [65:0] acc_q, mcand_q;
	logic [31:0] mplier_q;
	logic [5:0]  jcnt_q;
	logic [1:0]  jph_q;

	logic [31:0] pos;
	logic [31:0] hdr_next;
	logic [31:0] pos_inc;
	logic [31:0] start;
	logic [31:0] ppos;
	logic [33:0] lraw;
	logic [34:0] lpad;

	logic        pal_we;
	logic [7:0]  pal_waddr, pal_raddr;
	logic [1:0]  pal_lane;
	logic [7:0]  pb, pg, pr;
	logic [7:0]  idx, rd_idx;
	logic [2:0]  rd_slot;
	logic        fend_ok_body;
	logic [12:0] x;
	logic        visible;
	logic [2:0]  nslots;
	logic        need_emit;
	err_t        judge_err;
	logic        blue_ok, green_ok, red_ok;
	logic        hdr_at_end;

	assign pos      = cmd.start ? 32'd0 : pos_q;
	assign hdr_next = {data_byte, (cmd.start ? 24'd0 : hdr_q[31:8])};
	assign pos_inc  = pos + 32'd1;
	assign start    = (off_q < HEADER_BYTES) ? HEADER_BYTES : off_q;
	assign ppos     = pos - HEADER_BYTES;

	always_comb begin
		case (depth_q[4:0])
			5'd24:   lraw = {2'b0, rw_q} + {1'b0, rw_q, 1'b0};
			5'd1:    lraw = ({2'b0, rw_q} + 34'd7) >> 3;
			5'd4:    lraw = ({2'b0, rw_q} + 34'd1) >> 1;
			default: lraw = {2'b0, rw_q};
		endcase
		lpad = ({1'b0, lraw} + 35'd3) & ~35'd3;
	end

	// palette: three byte-wide rams, one per color lane
	assign fend_ok_body = in_body_q && !cmd.start;
	assign pal_waddr = ppos[9:2];
	assign pal_lane  = ppos[1:0];
	assign pal_we = cmd.take_byte && fend_ok_body && pos < start && ppos[31:10] == 22'd0
		&& pal_lane != 2'd3;

	bmpd_ram #(.WIDTH(8), .DEPTH(256)) u_pb (.clk, .we(pal_we && pal_lane == 2'd0),
		.waddr(pal_waddr), .wdata(data_byte), .raddr(pal_raddr), .rdata(pb));
	bmpd_ram #(.WIDTH(8), .DEPTH(256)) u_pg (.clk, .we(pal_we && pal_lane == 2'd1),
		.waddr(pal_waddr), .wdata(data_byte), .raddr(pal_raddr), .rdata(pg));
	bmpd_ram #(.WIDTH(8), .DEPTH(256)) u_pr (.clk, .we(pal_we && pal_lane == 2'd2),
		.waddr(pal_waddr), .wdata(data_byte), .raddr(pal_raddr), .rdata(pr));

	// slot decode
	always_comb begin
		idx = byte_q;
		x = '0;
		nslots = 3'd0;
		case (bpp_q)
			5'd1: begin
				idx = {7'd0, byte_q[3'd7 - slot_q]};
				x = 13'({cur_rbc_q, slot_q});
				nslots = 3'd7;
			end
			5'd4: begin
				idx = slot_q[0] ? {4'd0, byte_q[3:0]} : {4'd0, byte_q[7:4]};
				x = 13'({cur_rbc_q, slot_q[0]});
				nslots = 3'd1;
			end
			5'd8: begin
				x = cur_rbc_q[12:0];
			end
			default: begin
				x = x3_q;
			end
		endcase
		visible = ({1'b0, x} < {1'b0, w_q}) &&
			(cur_rbc_q[14:13] == 2'd0 || bpp_q == 5'd24) &&
			!(bpp_q == 5'd1 && cur_rbc_q[14:10] != 5'd0) &&
			!(bpp_q == 5'd4 && cur_rbc_q[14:12] != 3'd0);
	end

	// read address runs one slot ahead so each slot finds its entry registered
	assign rd_slot = (cmd.emit_step && !rd_wait_q) ? slot_q + 3'd1 : slot_q;

	always_comb begin
		case (bpp_q)
			5'd1:    rd_idx = {7'd0, byte_q[3'd7 - rd_slot]};
			5'd4:    rd_idx = rd_slot[0] ? {4'd0, byte_q[3:0]} : {4'd0, byte_q[7:4]};
			default: rd_idx = byte_q;
		endcase
	end
	assign pal_raddr = rd_idx;

	assign need_emit = (bpp_q != 5'd24) || (m3_q == 2'd2);

	always_comb begin
		if (sigbad_q) judge_err = ERR_SIGNATURE;
		else if (comp_q != 32'd0) judge_err = ERR_COMPRESSED;
		else if (depth_q != 16'd1 && depth_q != 16'd4 && depth_q != 16'd8 &&
			depth_q != 16'd24) judge_err = ERR_DEPTH;
		else if (acc_q > {34'd0, file_length}) judge_err = ERR_OVERRUN;
		else if (rw_q > 32'(MAX_WIDTH) || rh_q > 32'(MAX_HEIGHT)) judge_err = ERR_TOO_LARGE;
		else judge_err = ERR_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; hdr_q <= '0; off_q <= '0; rw_q <= '0; rh_q <= '0;
			comp_q <= '0; depth_q <= '0; sigbad_q <= 1'b0; fend_q <= 1'b0;
			w_q <= '0; h_q <= '0; bpp_q <= '0; rbc_q <= '0; prb_q <= '0;
			rc_q <= '0; part_q <= '0; slot_q <= '0; in_body_q <= 1'b0;
			jcnt_q <= '0; jph_q <= '0; pal_cnt_q <= '0; rd_wait_q <= 1'b0;
			line_q <= '0; m3_q <= '0; x3_q <= '0; m3c_q <= '0; d3c_q <= '0;
			byte_q <= '0; cur_rbc_q <= '0; cur_rc_q <= '0;
			acc_q <= '0; mcand_q <= '0; mplier_q <= '0;
		end else begin
			if (cmd.take_byte) begin
				fend_q <= ({1'b0, pos_inc} >= {1'b0, file_length}) || pos_inc == 32'd0;
				pos_q <= pos_inc;
				byte_q <= data_byte;
				cur_rbc_q <= rbc_q;
				cur_rc_q <= rc_q;
				slot_q <= '0;
				rd_wait_q <= 1'b1;
				if (cmd.start) begin
					off_q <= '0; rw_q <= '0; rh_q <= '0; comp_q <= '0; depth_q <= '0;
					sigbad_q <= 1'b0; w_q <= '0; h_q <= '0; bpp_q <= '0; prb_q <= '0;
					rc_q <= '0; rbc_q <= '0; part_q <= '0; in_body_q <= 1'b0;
					pal_cnt_q <= '0; m3c_q <= '0; d3c_q <= '0;
				end
				if (!in_body_q || cmd.start) begin
					hdr_q <= hdr_next;
					case (pos)
						32'd0:  if (data_byte != SIG_B) sigbad_q <= 1'b1;
						32'd1:  if (data_byte != SIG_M) sigbad_q <= 1'b1;
						32'd13: off_q <= hdr_next;
						32'd21: rw_q <= hdr_next;
						32'd25: rh_q <= hdr_next;
						32'd29: depth_q <= hdr_next[31:16];
						32'd33: comp_q <= hdr_next;
						default: ;
					endcase
					jcnt_q <= '0;
					jph_q <= '0;
				end else if (pos < start) begin
					if (ppos[31:10] == 22'd0)
						pal_cnt_q <= {1'b0, ppos[9:0]} + 11'd1;
				end else if ({3'd0, rc_q} < {3'd0, h_q} && w_q != 13'd0) begin
					m3_q <= m3c_q;
					x3_q <= d3c_q;
					if (bpp_q == 5'd24) begin
						if (m3c_q == 2'd0) part_q <= {8'd0, data_byte};
						else if (m3c_q == 2'd1) part_q[15:8] <= data_byte;
					end
					if (rbc_q + 15'd1 >= prb_q) begin
						rbc_q <= '0;
						rc_q <= rc_q + 13'd1;
						m3c_q <= '0;
						d3c_q <= '0;
					end else begin
						rbc_q <= rbc_q + 15'd1;
						if (m3c_q == 2'd2) begin
							m3c_q <= '0;
							d3c_q <= d3c_q + 13'd1;
						end else begin
							m3c_q <= m3c_q + 2'd1;
						end
					end
				end
			end
			if (cmd.judge_step) begin
				case (jph_q)
					2'd0: begin
						line_q <= lpad[31:0];
						acc_q <= {34'd0, off_q};
						mcand_q <= {31'd0, lpad};
						mplier_q <= rh_q;
						jcnt_q <= '0;
						jph_q <= 2'd1;
					end
					2'd1: begin
						if (mplier_q[0]) acc_q <= acc_q + mcand_q;
						mcand_q <= mcand_q << 1;
						mplier_q <= mplier_q >> 1;
						jcnt_q <= jcnt_q + 6'd1;
						if (jcnt_q == 6'd31) jph_q <= 2'd2;
					end
					default: begin
						if (judge_err == ERR_NONE) begin
							w_q <= rw_q[12:0];
							h_q <= rh_q[12:0];
							bpp_q <= depth_q[4:0];
							prb_q <= line_q[14:0];
							in_body_q <= 1'b1;
						end
					end
				endcase
			end
			if (cmd.emit_step) begin
				rd_wait_q <= 1'b0;
				if (!rd_wait_q)
					slot_q <= slot_q + 3'd1;
			end
		end
	end

	// lanes not yet written in this file read as zero
	assign blue_ok  = {1'b0, idx, 2'd0} < pal_cnt_q;
	assign green_ok = {1'b0, idx, 2'd1} < pal_cnt_q;
	assign red_ok   = {1'b0, idx, 2'd2} < pal_cnt_q;

	assign hdr_at_end = (pos == HEADER_BYTES - 32'd1);

	always_comb begin
		sts.file_end   = cmd.take_byte ? (({1'b0, pos_inc} >= {1'b0, file_length}) ||
			pos_inc == 32'd0) : fend_q;
		sts.short_file = file_length < HEADER_BYTES;
		sts.hdr_done   = hdr_at_end && !in_body_q;
		sts.judge_done = (jph_q == 2'd2);
		sts.judge_err  = judge_err;
		sts.byte_emits = in_body_q && pos >= start && {3'd0, rc_q} < {3'd0, h_q} &&
			w_q != 13'd0 && (bpp_q != 5'd24 || m3c_q == 2'd2);
		sts.emit_done  = !rd_wait_q && slot_q == nslots;
		sts.slot_valid = !rd_wait_q && visible && need_emit;
	end

	assign blue   = (bpp_q == 5'd24) ? part_q[7:0]  : (blue_ok ? pb : 8'd0);
	assign green  = (bpp_q == 5'd24) ? part_q[15:8] : (green_ok ? pg : 8'd0);
	assign red    = (bpp_q == 5'd24) ? byte_q       : (red_ok ? pr : 8'd0);
	assign column = x[11:0];
	assign row    = 12'(h_q - 13'd1 - cur_rc_q);
	assign last   = (cur_rc_q + 13'd1 == h_q) && (x + 13'd1 == w_q);
endmodule

@@ src/bmp_stream_decoder_core.sv @@
// BMP byte-stream decoder. Write file_length, then stream the file one byte per
// transfer. Header and palette bytes, and bytes past the last row, emit no pixels;
// every other body byte (row padding included, and for 24 bpp only the byte that
// completes a pixel) first waits for the palette read and then steps through its
// pixel slots (8 for 1 bpp, 2 for 4 bpp, 1 otherwise), and byte 53 starts a
// shift-add check of the image size against the file length.
module bmp_stream_decoder_core import bmpd_pkg::*; #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // error_code, blue, green, red, column, row
	output logic [0:0]  m_axis_tuser,  // kind
	output logic        m_axis_tlast
);
	logic [31:0] file_length_q;
	cmd_t cmd;
	sts_t sts;
	logic err_push, pix_push;
	err_t err_code;
	logic [7:0] b, g, r;
	logic [11:0] col, rw;
	logic lst;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			file_length_q <= '0;
		else if (cfg_valid)
			file_length_q <= cfg_data;
	end

	logic out_busy;
	assign out_busy = m_axis_tvalid && !m_axis_tready;

	bmpd_ctrl u_ctrl (
		.clk, .arst_n, .in_valid(s_axis_tvalid), .out_busy, .sts, .cmd,
		.in_ready(s_axis_tready), .err_push, .err_code, .pix_push
	);

	bmpd_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
		.clk, .arst_n, .file_length(file_length_q), .data_byte(s_axis_tdata), .cmd, .sts,
		.blue(b), .green(g), .red(r), .column(col), .row(rw), .last(lst)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tvalid <= 1'b0;
		else if (err_push || pix_push)
			m_axis_tvalid <= 1'b1;
		else if (m_axis_tready)
			m_axis_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (err_push) begin
			m_axis_tdata <= {5'd0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0, err_code};
			m_axis_tuser <= 1'b1;
			m_axis_tlast <= 1'b1;
		end else if (pix_push) begin
			m_axis_tdata <= {5'd0, rw, col, r, g, b, ERR_NONE};
			m_axis_tuser <= 1'b0;
			m_axis_tlast <= lst;
		end
	end
endmodule
